### hdl/iterative_quicksort_unit_assert.svh
// Assertion macros shared by the checker.
// No dependencies.
`ifndef ITERATIVE_QUICKSORT_UNIT_ASSERT_SVH
`define ITERATIVE_QUICKSORT_UNIT_ASSERT_SVH
`define IQS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("violation");
`define IQS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("violation");
`endif

### hdl/iqs_pkg.sv
// Types and state codes for the iterative quicksort unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iqs_pkg;
  typedef enum logic [3:0] {
    ST_LOAD, ST_POP, ST_POP_RD, ST_PIV_RD, ST_PIV, ST_SCANL_RD, ST_SCANL,
    ST_SCANR_RD, ST_SCANR, ST_SWAPA, ST_SWAPB, ST_PUSH1, ST_PUSH2,
    ST_EMIT_RD, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

### hdl/iqs_stream_if.sv
// Valid/ready channel interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface iqs_stream_if #(parameter int W = 34);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/iqs_front.sv
// Front part: accepts requests into a two-entry queue.
// Depends on iqs_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module iqs_front #(parameter int W = 34) (
  input  wire logic clk,
  input  wire logic rst,
  iqs_stream_if.sink   in_ch,
  iqs_stream_if.source q_ch
);
  logic [W-1:0] buf_q [2];
  logic [1:0]   cnt;
  logic         rd;
  assign in_ch.ready = (cnt != 2'd2);
  assign q_ch.valid = (cnt != 2'd0);
  assign q_ch.data = buf_q[rd];
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) buf_q[rd ^ cnt[0]] <= in_ch.data;
      if (q_ch.valid && q_ch.ready) rd <= ~rd;
      cnt <= cnt + 2'(in_ch.valid && in_ch.ready) - 2'(q_ch.valid && q_ch.ready);
    end
  end
endmodule
`default_nettype wire

### hdl/iqs_back.sv
// Back part: store, bound stacks and sort/emit sequencer.
// Depends on iqs_pkg, iqs_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module iqs_back #(parameter int DEPTH = 64, parameter int DATA_WIDTH = 32) (
  input  wire logic clk,
  input  wire logic rst,
  iqs_stream_if.sink   q_ch,
  iqs_stream_if.source out_ch
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic signed [CW:0] ONE_S = (CW+1)'(1);
  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [CW:0] idx_t;

  iqs_pkg::state_t state, state_next;
  data_t mem [DEPTH];
  logic [AW-1:0] lo_stk [DEPTH];
  logic [AW-1:0] hi_stk [DEPTH];
  logic [CW-1:0] count, sp, k, load_n;
  logic ovf;
  idx_t lo, hi, pl, pr, pl_inc, pr_dec, sumlh;
  data_t pivot, rdata, vl, vr, in_v, outv, mem_wdata;
  logic outvalid, outlast, outovf;
  logic in_last, acc, has_room, do_sort, out_free, load_out, small_left;
  logic [AW-1:0] raddr, mem_waddr;
  logic [AW-1:0] stk_raddr, stk_rlo, stk_rhi, stk_waddr, stk_wlo, stk_whi;
  logic mem_we, stk_we;

  assign in_v = q_ch.data[DATA_WIDTH:1];
  assign in_last = q_ch.data[0];
  assign acc = q_ch.valid && q_ch.ready;
  assign has_room = (count < CW'(DEPTH));
  assign load_n = has_room ? count + CW'(1) : count;
  assign do_sort = (load_n >= CW'(2));
  assign out_free = !outvalid || out_ch.ready;
  assign load_out = (state == iqs_pkg::ST_EMIT) && out_free;
  assign q_ch.ready = (state == iqs_pkg::ST_LOAD);
  assign out_ch.valid = outvalid;
  assign out_ch.data = {outv, outlast, outovf};
  assign pl_inc = pl + ONE_S;
  assign pr_dec = pr - ONE_S;
  assign sumlh = lo + hi;
  assign small_left = (pr - lo) < (hi - pl);

  always_comb begin
    state_next = state;
    unique case (state)
      iqs_pkg::ST_LOAD:
        if (acc && in_last) state_next = do_sort ? iqs_pkg::ST_POP : iqs_pkg::ST_EMIT_RD;
      iqs_pkg::ST_POP:
        state_next = (sp == '0) ? iqs_pkg::ST_EMIT_RD : iqs_pkg::ST_POP_RD;
      iqs_pkg::ST_POP_RD: state_next = iqs_pkg::ST_PIV_RD;
      iqs_pkg::ST_PIV_RD: state_next = iqs_pkg::ST_PIV;
      iqs_pkg::ST_PIV: state_next = iqs_pkg::ST_SCANL_RD;
      iqs_pkg::ST_SCANL_RD: state_next = iqs_pkg::ST_SCANL;
      iqs_pkg::ST_SCANL:
        state_next = (pl < hi && rdata < pivot) ? iqs_pkg::ST_SCANL_RD : iqs_pkg::ST_SCANR_RD;
      iqs_pkg::ST_SCANR_RD: state_next = iqs_pkg::ST_SCANR;
      iqs_pkg::ST_SCANR: begin
        if (pr > lo && pivot < rdata) state_next = iqs_pkg::ST_SCANR_RD;
        else if (pl <= pr) state_next = iqs_pkg::ST_SWAPA;
        else state_next = iqs_pkg::ST_PUSH1;
      end
      iqs_pkg::ST_SWAPA: state_next = iqs_pkg::ST_SWAPB;
      iqs_pkg::ST_SWAPB:
        state_next = (pl_inc <= pr_dec) ? iqs_pkg::ST_SCANL_RD : iqs_pkg::ST_PUSH1;
      iqs_pkg::ST_PUSH1: state_next = iqs_pkg::ST_PUSH2;
      iqs_pkg::ST_PUSH2: state_next = iqs_pkg::ST_POP;
      iqs_pkg::ST_EMIT_RD: state_next = iqs_pkg::ST_EMIT;
      iqs_pkg::ST_EMIT:
        if (out_free)
          state_next = (k == count - CW'(1)) ? iqs_pkg::ST_LOAD : iqs_pkg::ST_EMIT_RD;
      default: state_next = iqs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    raddr = '0;
    stk_raddr = AW'(sp - CW'(1));
    mem_we = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = in_v;
    stk_we = 1'b0;
    stk_waddr = sp[AW-1:0];
    stk_wlo = '0;
    stk_whi = '0;
    unique case (state) inside
      iqs_pkg::ST_LOAD: begin
        mem_we = acc && has_room;
        stk_we = acc && in_last && do_sort;
        stk_waddr = '0;
        stk_whi = has_room ? count[AW-1:0] : AW'(DEPTH - 1);
      end
      iqs_pkg::ST_PIV_RD, iqs_pkg::ST_PIV: raddr = sumlh[AW:1];
      iqs_pkg::ST_SCANL_RD, iqs_pkg::ST_SCANL: raddr = pl[AW-1:0];
      iqs_pkg::ST_SCANR_RD, iqs_pkg::ST_SCANR: raddr = pr[AW-1:0];
      iqs_pkg::ST_SWAPA: begin
        mem_we = 1'b1;
        mem_waddr = pl[AW-1:0];
        mem_wdata = vr;
      end
      iqs_pkg::ST_SWAPB: begin
        mem_we = 1'b1;
        mem_waddr = pr[AW-1:0];
        mem_wdata = vl;
      end
      // larger part goes on the stack first
      iqs_pkg::ST_PUSH1: begin
        if (small_left) begin
          stk_we = (pl < hi);
          stk_wlo = pl[AW-1:0];
          stk_whi = hi[AW-1:0];
        end else begin
          stk_we = (lo < pr);
          stk_wlo = lo[AW-1:0];
          stk_whi = pr[AW-1:0];
        end
      end
      iqs_pkg::ST_PUSH2: begin
        if (small_left) begin
          stk_we = (lo < pr);
          stk_wlo = lo[AW-1:0];
          stk_whi = pr[AW-1:0];
        end else begin
          stk_we = (pl < hi);
          stk_wlo = pl[AW-1:0];
          stk_whi = hi[AW-1:0];
        end
      end
      iqs_pkg::ST_EMIT_RD, iqs_pkg::ST_EMIT: raddr = k[AW-1:0];
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      lo_stk[stk_waddr] <= stk_wlo;
      hi_stk[stk_waddr] <= stk_whi;
    end
    stk_rlo <= lo_stk[stk_raddr];
    stk_rhi <= hi_stk[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iqs_pkg::ST_LOAD;
      count <= '0;
      sp <= '0;
      ovf <= 1'b0;
      k <= '0;
      outvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        outvalid <= 1'b1;
        outv <= rdata;
        outlast <= (k == count - CW'(1));
        outovf <= ovf;
      end else if (out_ch.ready) outvalid <= 1'b0;
      unique case (state) inside
        iqs_pkg::ST_LOAD: if (acc) begin
          if (has_room) count <= count + CW'(1);
          else ovf <= 1'b1;
          if (in_last) begin
            k <= '0;
            sp <= do_sort ? CW'(1) : '0;
          end
        end
        iqs_pkg::ST_POP: if (sp != '0) sp <= sp - CW'(1);
        iqs_pkg::ST_POP_RD: begin
          lo <= $signed({2'b00, stk_rlo});
          hi <= $signed({2'b00, stk_rhi});
          pl <= $signed({2'b00, stk_rlo});
          pr <= $signed({2'b00, stk_rhi});
        end
        iqs_pkg::ST_PIV: pivot <= rdata;
        iqs_pkg::ST_SCANL: begin
          if (pl < hi && rdata < pivot) pl <= pl_inc;
          else vl <= rdata;
        end
        iqs_pkg::ST_SCANR: begin
          if (pr > lo && pivot < rdata) pr <= pr_dec;
          else vr <= rdata;
        end
        iqs_pkg::ST_SWAPB: begin
          pl <= pl_inc;
          pr <= pr_dec;
        end
        iqs_pkg::ST_PUSH1, iqs_pkg::ST_PUSH2: if (stk_we) sp <= sp + CW'(1);
        iqs_pkg::ST_EMIT: if (load_out) begin
          if (k == count - CW'(1)) begin
            count <= '0;
            sp <= '0;
            ovf <= 1'b0;
          end else k <= k + CW'(1);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/iterative_quicksort_unit.sv
// Top level of the iterative quicksort unit.
// Depends on iqs_pkg, iqs_stream_if, iqs_front, iqs_back.
//   channel  dir  payload
//   in_ch    in   {value, last}
//   out_ch   out  {sorted_value, final_res, overflowed}
// Loading takes one request per cycle through a two-entry queue in ST_LOAD.
// Each partition pops a range and fetches the pivot, then takes a read and a
// compare state per scan step, two write states per swap and two push states.
// Each result is read, then loaded out; an out_ch stall holds the sequencer.
// The back part takes no request from a set's last one until its final result
// is loaded. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none
module iterative_quicksort_unit #(parameter int DEPTH = 64, parameter int DATA_WIDTH = 32) (
  input wire logic clk,
  input wire logic rst,
  iqs_stream_if.sink   in_ch,
  iqs_stream_if.source out_ch
);
  iqs_stream_if #(.W(DATA_WIDTH + 1)) q_ch ();
  iqs_front #(.W(DATA_WIDTH + 1)) u_front (.clk, .rst, .in_ch, .q_ch);
  iqs_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (.clk, .rst, .q_ch, .out_ch);
endmodule
`default_nettype wire

### hdl/iqs_checker.sv
// Port checker for the iterative quicksort unit, bound to the top level.
// Depends on iterative_quicksort_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "iterative_quicksort_unit_assert.svh"
module iqs_port_checker #(parameter int W = 34) (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [W-1:0] out_data
);
  `IQS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `IQS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
  `IQS_ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !out_valid)
  `IQS_ASSERT_NEXT(a_rst_ready, clk, 1'b0, rst, in_ready)
endmodule
bind iterative_quicksort_unit iqs_port_checker #(.W(DATA_WIDTH + 2)) u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire

### bench/iqs_checker.sv
// Checker for the iterative quicksort unit: watches both channels, predicts
// the sorted output of each set and compares it. No dependencies.
`timescale 1ns / 1ps
module iqs_checker #(parameter int DEPTH = 64, parameter int DATA_WIDTH = 32) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [DATA_WIDTH:0] in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [DATA_WIDTH+1:0] out_data,
  output int   errors,
  output int   pending,
  output int   sets_sorted,
  output int   results_seen
);
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         final_res;
    logic                         overflowed;
  } sorted_item_t;

  logic signed [DATA_WIDTH-1:0] set_values[$];
  logic                         set_dropped;
  sorted_item_t                 sorted_fifo[$];

  // iterative Hoare partition quicksort, middle pivot, larger part pushed first
  task automatic sort_set();
    int lo_stk[$];
    int hi_stk[$];
    int lo, hi, pl, pr, n;
    logic signed [DATA_WIDTH-1:0] pivot, t;
    n = set_values.size();
    if (n >= 2) begin
      lo_stk.push_back(0);
      hi_stk.push_back(n - 1);
    end
    while (lo_stk.size() > 0) begin
      lo = lo_stk.pop_back();
      hi = hi_stk.pop_back();
      pl = lo;
      pr = hi;
      pivot = set_values[(lo + hi) / 2];
      do begin
        while (pl < hi && set_values[pl] < pivot) pl++;
        while (pr > lo && pivot < set_values[pr]) pr--;
        if (pl <= pr) begin
          t = set_values[pl];
          set_values[pl] = set_values[pr];
          set_values[pr] = t;
          pl++;
          pr--;
        end
      end while (pl <= pr);
      if ((pr - lo) < (hi - pl)) begin
        if (pl < hi) begin lo_stk.push_back(pl); hi_stk.push_back(hi); end
        if (lo < pr) begin lo_stk.push_back(lo); hi_stk.push_back(pr); end
      end else begin
        if (lo < pr) begin lo_stk.push_back(lo); hi_stk.push_back(pr); end
        if (pl < hi) begin lo_stk.push_back(pl); hi_stk.push_back(hi); end
      end
    end
  endtask

  always @(posedge clk) begin
    sorted_item_t got, want;
    if (rst) begin
      set_values.delete();
      set_dropped = 1'b0;
      sorted_fifo.delete();
      errors = 0;
      pending = 0;
      sets_sorted = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        results_seen++;
        if (sorted_fifo.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = sorted_fifo.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected val=%0d fin=%b ovf=%b, got val=%0d fin=%b ovf=%b",
                       want.sorted_value, want.final_res, want.overflowed,
                       got.sorted_value, got.final_res, got.overflowed);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (set_values.size() < DEPTH) set_values.push_back(in_data[DATA_WIDTH:1]);
        else set_dropped = 1'b1;
        if (in_data[0]) begin
          sort_set();
          foreach (set_values[k]) begin
            want.sorted_value = set_values[k];
            want.final_res = (k == set_values.size() - 1);
            want.overflowed = set_dropped;
            sorted_fifo.push_back(want);
          end
          set_values.delete();
          set_dropped = 1'b0;
          sets_sorted++;
        end
      end
      pending = sorted_fifo.size();
    end
  end
endmodule

### bench/testbench.sv
// Top of the iterative quicksort bench: clock, reset, request stimulus and
// verdict. Depends on iqs_stream_if, iqs_checker, iterative_quicksort_unit.
`timescale 1ns / 1ps
module testbench;
  localparam int DEPTH = 64;
  localparam int DW = 32;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors, pending, sets_sorted, results_seen;
  int   requests_sent = 0;
  bit   hold_off = 1'b0;

  iqs_stream_if #(.W(DW + 1)) in_ch ();
  iqs_stream_if #(.W(DW + 2)) out_ch ();

  iterative_quicksort_unit #(.DEPTH(DEPTH), .DATA_WIDTH(DW)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  iqs_checker #(.DEPTH(DEPTH), .DATA_WIDTH(DW)) chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .errors(errors), .pending(pending), .sets_sorted(sets_sorted),
    .results_seen(results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 4;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off while the sender fills the block
  initial begin
    int g;
    int i;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (i = 0; i < 600; i++) @(posedge clk);
        hold_off = 1'b0;
        out_ch.ready <= 1'b1;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          for (i = 0; i < g; i++) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [DW-1:0] v, input logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {v, lst};
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  task automatic send_set(input int n);
    int k;
    for (k = 0; k < n; k++) send(pick_value(), k == n - 1);
  endtask

  initial begin
    int n;
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // single element, a two-element set in reverse order, a five-element set, duplicates, extremes
    send(32'h8000_0000, 1'b1);
    send(32'h7fff_ffff, 1'b0);
    send(32'h8000_0000, 1'b1);
    send(32'h0000_0001, 1'b0);
    send(32'hffff_ffff, 1'b0);
    send(32'h0000_0001, 1'b0);
    send(32'h0000_0000, 1'b0);
    send(32'hffff_ffff, 1'b1);
    for (k = 0; k < 6; k++) send(32'h5, k == 5);
    for (k = 0; k < 6; k++) send(32'h7fff_fff0 - k, k == 5);
    // overflow: capacity plus a few, last request itself dropped
    hold_off = 1'b1;
    for (k = 0; k < DEPTH + 3; k++) send($urandom(), k == DEPTH + 2);
    while (requests_sent < 200) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, DEPTH) : $urandom_range(1, 12);
      send_set(n);
    end
    // exactly full set
    for (k = 0; k < DEPTH; k++) send($urandom(), k == DEPTH - 1);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests in %0d sets, %0d sorted results checked",
             requests_sent, sets_sorted, results_seen);
    if (errors == 0 && pending == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
